// ===== hdl/dmx_channels_to_pixel_colors_macros.svh =====
// Assertion macros for the DMX pixel mapper.
// Both expect aclk and aresetn in scope of the module that uses them.
`ifndef DMX_CHANNELS_TO_PIXEL_COLORS_MACROS_SVH
`define DMX_CHANNELS_TO_PIXEL_COLORS_MACROS_SVH

`ifndef SYNTHESIS

// Flag a condition that must never be true outside reset.
`define DMXPX_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

// Flag an implication that fails outside reset.
`define DMXPX_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define DMXPX_NEVER(label, cond, msg)
`define DMXPX_IMPLY(label, ante, cons, msg)

`endif

`endif

// ===== hdl/dmxpx_pkg.sv =====
`default_nettype none

package dmxpx_pkg;

    localparam int ChanW   = 8;
    localparam int CountW  = 10;
    localparam int IndexW  = 9;
    localparam int TotalW  = 16;
    localparam int PerW    = 11;
    localparam int CopiesW = 7;
    localparam int PosW    = 3;
    localparam int NumCol  = 5;

    // Group sizes as written to the channels_per_group register
    localparam logic [PosW-1:0] GROUP_RGB   = 3'd3;
    localparam logic [PosW-1:0] GROUP_RGBW  = 3'd4;
    localparam logic [PosW-1:0] GROUP_RGBCW = 3'd5;

    // Channel positions inside a tuple
    localparam logic [PosW-1:0] POS_RED   = 3'd1;
    localparam logic [PosW-1:0] POS_GREEN = 3'd2;
    localparam logic [PosW-1:0] POS_BLUE  = 3'd3;

    // Copies per tuple are capped here
    localparam logic [CopiesW-1:0] COPIES_MAX = 7'd64;

    // Configuration register indexes
    localparam logic CFG_GROUP  = 1'b0;
    localparam logic CFG_COPIES = 1'b1;

    // Color lanes in the back end
    localparam int COL_RED   = 0;
    localparam int COL_GREEN = 1;
    localparam int COL_BLUE  = 2;
    localparam int COL_COLD  = 3;
    localparam int COL_WARM  = 4;

    // One completed tuple, undimmed, as it waits in the queue
    typedef struct packed {
        logic             clear;
        logic [ChanW-1:0] dim;
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] cold;
        logic [ChanW-1:0] warm;
    } tuple_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCALE,
        BK_EMIT
    } back_state_t;

    // Exact floor(p / 255) for any product of two bytes
    function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] p);
        logic [2*ChanW:0] s;
        s = (2*ChanW+1)'(p) + (2*ChanW+1)'(p[2*ChanW-1:ChanW]) + (2*ChanW+1)'(1);
        return s[2*ChanW-1:ChanW];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dmxpx_front.sv =====
`default_nettype none

module dmxpx_front
    import dmxpx_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [ChanW-1:0]   channel_value,
    input  wire logic [ChanW-1:0]   dim_level,
    input  wire logic               frame_start,
    input  wire logic [PosW-1:0]    channels_per_group,
    input  wire queue_status_t      q_status,
    output logic                    push,
    output tuple_t                  push_data
);

    logic [PosW-1:0]  pos_reg,   pos_next;
    logic [ChanW-1:0] red_reg,   red_next;
    logic [ChanW-1:0] green_reg, green_next;
    logic [ChanW-1:0] blue_reg,  blue_next;
    logic [ChanW-1:0] cold_reg,  cold_next;
    logic             clear_reg, clear_next;

    logic             accept;
    logic [PosW-1:0]  group;
    logic [PosW-1:0]  pos_eff;
    logic [ChanW-1:0] red_eff, green_eff, blue_eff, cold_eff;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && !q_status.full;

    // Gather bytes into a tuple and hand completed tuples to the queue
    always_comb begin
        if (channels_per_group == GROUP_RGBW || channels_per_group == GROUP_RGBCW) begin
            group = channels_per_group;
        end else begin
            group = GROUP_RGB;
        end

        // Frame start restarts the tuple before this byte is taken
        pos_eff   = frame_start ? POS_RED : pos_reg;
        red_eff   = frame_start ? '0 : red_reg;
        green_eff = frame_start ? '0 : green_reg;
        blue_eff  = frame_start ? '0 : blue_reg;
        cold_eff  = frame_start ? '0 : cold_reg;

        push_data.clear = clear_reg || frame_start;
        push_data.dim   = dim_level;
        push_data.red   = red_eff;
        push_data.green = green_eff;
        push_data.blue  = (group == GROUP_RGB) ? channel_value : blue_eff;
        push_data.cold  = (group == GROUP_RGBCW) ? cold_eff : '0;
        push_data.warm  = (group == GROUP_RGB) ? '0 : channel_value;

        pos_next   = pos_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        cold_next  = cold_reg;
        clear_next = clear_reg;
        push       = 1'b0;

        if (accept) begin
            if (frame_start) begin
                clear_next = 1'b1;
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
                cold_next  = '0;
            end
            if (pos_eff < group) begin
                case (pos_eff)
                    POS_RED:   red_next   = channel_value;
                    POS_GREEN: green_next = channel_value;
                    POS_BLUE:  blue_next  = channel_value;
                    default:   cold_next  = channel_value;
                endcase
                pos_next = pos_eff + PosW'(1);
            end else begin
                push       = 1'b1;
                pos_next   = POS_RED;
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_RED;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            cold_reg  <= '0;
            clear_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            cold_reg  <= cold_next;
            clear_reg <= clear_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmxpx_queue.sv =====
`default_nettype none

module dmxpx_queue
    import dmxpx_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire tuple_t push_data,
    input  wire logic   pop,
    output tuple_t      pop_data,
    output queue_status_t status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tuple_t          entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming tuple
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmxpx_back.sv =====
`default_nettype none

module dmxpx_back
    import dmxpx_pkg::*;
#(
    parameter int MAX_PIXELS = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire queue_status_t            q_status,
    input  wire tuple_t                   head,
    output logic                          pop,
    input  wire logic [CopiesW-1:0]       pixels_per_section,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [IndexW-1:0]             pixel_index,
    output logic [NumCol-1:0][ChanW-1:0]  colors,
    output logic [TotalW-1:0]             power_total,
    output logic                          last
);

    localparam logic [CountW-1:0] PixLimit = CountW'(MAX_PIXELS);

    back_state_t                    state_reg, state_next;
    logic [NumCol-1:0][2*ChanW-1:0] prod_reg,  prod_next;
    logic [NumCol-1:0][ChanW-1:0]   color_reg, color_next;
    logic [PerW-1:0]                per_reg,   per_next;
    logic [CopiesW-1:0]             copies_reg, copies_next;
    logic [CountW-1:0]              count_reg, count_next;
    logic [TotalW-1:0]              total_reg, total_next;

    logic                           out_valid_reg, out_valid_next;
    logic [IndexW-1:0]              out_index_reg, out_index_next;
    logic [NumCol-1:0][ChanW-1:0]   out_color_reg, out_color_next;
    logic [TotalW-1:0]              out_total_reg, out_total_next;
    logic                           out_last_reg,  out_last_next;

    logic                           emit_ok;
    logic                           slot_free;
    logic                           last_write;
    logic [TotalW:0]                total_sum;

    assign emit_ok    = (copies_reg != '0) && (count_reg < PixLimit);
    assign slot_free  = !out_valid_reg || m_tready;
    assign last_write = (copies_reg == CopiesW'(1)) || ((count_reg + CountW'(1)) == PixLimit);
    assign total_sum  = (TotalW+1)'(total_reg) + (TotalW+1)'(per_reg);

    assign m_tvalid    = out_valid_reg;
    assign pixel_index = out_index_reg;
    assign colors      = out_color_reg;
    assign power_total = out_total_reg;
    assign last        = out_last_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE: begin
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (!emit_ok) begin
                    state_next = BK_IDLE;
                end else if (slot_free && last_write) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and output register
    always_comb begin
        pop            = 1'b0;
        prod_next      = prod_reg;
        color_next     = color_reg;
        per_next       = per_reg;
        copies_next    = copies_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_color_next = out_color_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            BK_IDLE: begin
                // Take the next tuple and multiply by the dimmer
                if (!q_status.empty) begin
                    pop = 1'b1;
                    prod_next[COL_RED]   = (2*ChanW)'(head.red)   * (2*ChanW)'(head.dim);
                    prod_next[COL_GREEN] = (2*ChanW)'(head.green) * (2*ChanW)'(head.dim);
                    prod_next[COL_BLUE]  = (2*ChanW)'(head.blue)  * (2*ChanW)'(head.dim);
                    prod_next[COL_COLD]  = (2*ChanW)'(head.cold)  * (2*ChanW)'(head.dim);
                    prod_next[COL_WARM]  = (2*ChanW)'(head.warm)  * (2*ChanW)'(head.dim);
                    if (head.clear) begin
                        count_next = '0;
                        total_next = '0;
                    end
                    copies_next = (pixels_per_section > COPIES_MAX) ? COPIES_MAX
                                                                    : pixels_per_section;
                end
            end
            BK_SCALE: begin
                // Divide by full scale and form the per-write brightness
                for (int i = 0; i < NumCol; i++) begin
                    color_next[i] = div255(prod_reg[i]);
                end
                per_next = PerW'(color_next[COL_RED]) + PerW'(color_next[COL_GREEN])
                         + PerW'(color_next[COL_BLUE]) + PerW'(color_next[COL_COLD])
                         + PerW'(color_next[COL_WARM]);
            end
            BK_EMIT: begin
                // Write one copy whenever the output register is free
                if (emit_ok && slot_free) begin
                    out_valid_next = 1'b1;
                    out_index_next = count_reg[IndexW-1:0];
                    out_color_next = color_reg;
                    total_next     = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
                    out_total_next = total_next;
                    out_last_next  = last_write;
                    count_next     = count_reg + CountW'(1);
                    copies_next    = copies_reg - CopiesW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            copies_reg    <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            copies_reg    <= copies_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        color_reg     <= color_next;
        per_reg       <= per_next;
        out_index_reg <= out_index_next;
        out_color_reg <= out_color_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== hdl/dmx_channels_to_pixel_colors.sv =====
// Channel   | Direction | Carries
// s_        | in        | one DMX channel byte with the frame dimmer and frame start
// m_        | out       | one pixel write: index, dimmed colors, running brightness
// cfg_      | in        | register writes: group size, copies per tuple
//
// A byte is taken every cycle while the tuple queue has room.
// Each completed tuple passes through two back-end steps (multiply, scale),
// then one cycle per pixel copy, so the copy loop sets the sustained rate.
// The output register refills in the cycle its write is taken; a stalled write
// holds the copy loop until m_tready returns.
// aresetn is synchronous and active low; no clearing pass follows it.
`default_nettype none
`include "dmx_channels_to_pixel_colors_macros.svh"

module dmx_channels_to_pixel_colors
    import dmxpx_pkg::*;
#(
    parameter int MAX_PIXELS  = 512,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // channel_value[7:0], dim_level[15:8]
    input  wire logic         s_tuser,   // frame_start
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pixel_index[8:0], red[16:9], green[24:17], blue[32:25], cold_white[40:33],
    // warm_white[48:41], power_total[64:49], zero[71:65]
    output logic [71:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [6:0]   cfg_wdata
);

    logic [PosW-1:0]               group_reg;
    logic [CopiesW-1:0]            copies_reg;

    logic                          q_push;
    logic                          q_pop;
    tuple_t                        q_in;
    tuple_t                        q_head;
    queue_status_t                 q_status;

    logic [IndexW-1:0]             pixel_index;
    logic [NumCol-1:0][ChanW-1:0]  colors;
    logic [TotalW-1:0]             power_total;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg  <= GROUP_RGB;
            copies_reg <= CopiesW'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GROUP:  group_reg  <= cfg_wdata[PosW-1:0];
                CFG_COPIES: copies_reg <= cfg_wdata[CopiesW-1:0];
                default: begin
                end
            endcase
        end
    end

    dmxpx_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .channel_value      (s_tdata[7:0]),
        .dim_level          (s_tdata[15:8]),
        .frame_start        (s_tuser),
        .channels_per_group (group_reg),
        .q_status           (q_status),
        .push               (q_push),
        .push_data          (q_in)
    );

    dmxpx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_head),
        .status    (q_status)
    );

    dmxpx_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_status           (q_status),
        .head               (q_head),
        .pop                (q_pop),
        .pixels_per_section (copies_reg),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .pixel_index        (pixel_index),
        .colors             (colors),
        .power_total        (power_total),
        .last               (m_tlast)
    );

    assign m_tdata = {7'd0, power_total, colors[COL_WARM], colors[COL_COLD],
                      colors[COL_BLUE], colors[COL_GREEN], colors[COL_RED], pixel_index};

    `DMXPX_NEVER(a_push_when_full, q_push && q_status.full, "tuple pushed into a full queue")
    `DMXPX_NEVER(a_pop_when_empty, q_pop && q_status.empty, "tuple popped from an empty queue")
    `DMXPX_IMPLY(a_full_after_push, $rose(q_status.full), $past(q_push), "queue filled without a push")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dmxpx_pkg::*;

    localparam int PIXEL_LIMIT  = 512;
    localparam int QUIET_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_BYTES  = 51;

    // A group size the block does not know; it behaves as RGB
    localparam logic [PosW-1:0]    GROUP_UNKNOWN = 3'd6;
    // Copy count above the cap
    localparam logic [CopiesW-1:0] COPIES_OVER   = 7'd127;

    // One pixel write as it leaves the block
    typedef struct packed {
        logic [IndexW-1:0] pixel_index;
        logic [ChanW-1:0]  red;
        logic [ChanW-1:0]  green;
        logic [ChanW-1:0]  blue;
        logic [ChanW-1:0]  cold_white;
        logic [ChanW-1:0]  warm_white;
        logic [TotalW-1:0] power_total;
        logic              last_write;
    } pixel_write_t;

    // Predicts pixel writes from channel bytes and checks them in order
    class pixel_write_tracker;
        logic [PosW-1:0]    group_reg;
        logic [CopiesW-1:0] copies_reg;
        logic [PosW-1:0]    position;
        logic [ChanW-1:0]   held_red;
        logic [ChanW-1:0]   held_green;
        logic [ChanW-1:0]   held_blue;
        logic [ChanW-1:0]   held_cold;
        int unsigned        pixel_count;
        int unsigned        power_sum;
        pixel_write_t       expected_writes[$];
        int unsigned        failures;

        function new();
            group_reg  = GROUP_RGB;
            copies_reg = 7'd1;
            failures   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position    = POS_RED;
            held_red    = '0;
            held_green  = '0;
            held_blue   = '0;
            held_cold   = '0;
            pixel_count = 0;
            power_sum   = 0;
        endfunction

        function void set_regs(logic [PosW-1:0] group, logic [CopiesW-1:0] copies);
            group_reg  = group;
            copies_reg = copies;
        endfunction

        function logic [ChanW-1:0] dimmed(logic [ChanW-1:0] x, logic [ChanW-1:0] d);
            int unsigned xi;
            int unsigned di;
            xi = x;
            di = d;
            return ChanW'((xi * di) / 255);
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // Take one channel byte; queue the writes it causes
        function void note_byte(logic [ChanW-1:0] value, logic [ChanW-1:0] dimmer,
                                logic start);
            int unsigned  grp;
            int unsigned  copies;
            int unsigned  per;
            int unsigned  n;
            pixel_write_t w;
            if (start) clear_frame();
            grp = (group_reg == GROUP_RGBW || group_reg == GROUP_RGBCW) ? group_reg : GROUP_RGB;
            // hold the channel until the tuple is complete
            if (position < grp) begin
                case (position)
                    POS_RED:   held_red   = value;
                    POS_GREEN: held_green = value;
                    POS_BLUE:  held_blue  = value;
                    default:   held_cold  = value;
                endcase
                position = position + 1'b1;
                return;
            end
            position       = POS_RED;
            w.red          = dimmed(held_red, dimmer);
            w.green        = dimmed(held_green, dimmer);
            w.last_write   = 1'b0;
            if (grp == GROUP_RGB) begin
                w.blue       = dimmed(value, dimmer);
                w.cold_white = '0;
                w.warm_white = '0;
            end else if (grp == GROUP_RGBW) begin
                w.blue       = dimmed(held_blue, dimmer);
                w.cold_white = '0;
                w.warm_white = dimmed(value, dimmer);
            end else begin
                w.blue       = dimmed(held_blue, dimmer);
                w.cold_white = dimmed(held_cold, dimmer);
                w.warm_white = dimmed(value, dimmer);
            end
            per = w.red + w.green + w.blue + w.cold_white + w.warm_white;
            copies = (copies_reg > COPIES_MAX) ? COPIES_MAX : copies_reg;
            n = 0;
            // replicate, dropping writes past the last pixel
            for (int unsigned j = 0; j < copies; j++) begin
                if (pixel_count >= PIXEL_LIMIT) break;
                power_sum = power_sum + per;
                if (power_sum > 65535) power_sum = 65535;
                w.pixel_index = IndexW'(pixel_count);
                w.power_total = TotalW'(power_sum);
                expected_writes.push_back(w);
                pixel_count++;
                n++;
            end
            if (n > 0) expected_writes[expected_writes.size() - 1].last_write = 1'b1;
        endfunction

        function string show(pixel_write_t w);
            return $sformatf("idx=%0d r=%0d g=%0d b=%0d cw=%0d ww=%0d pwr=%0d last=%0b",
                             w.pixel_index, w.red, w.green, w.blue, w.cold_white,
                             w.warm_white, w.power_total, w.last_write);
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= 10) $display("%s", what);
        endfunction

        // Compare one accepted write against the oldest prediction
        function void check_write(logic [71:0] data, logic tlast);
            pixel_write_t got;
            pixel_write_t want;
            got.pixel_index = data[8:0];
            got.red         = data[16:9];
            got.green       = data[24:17];
            got.blue        = data[32:25];
            got.cold_white  = data[40:33];
            got.warm_white  = data[48:41];
            got.power_total = data[64:49];
            got.last_write  = tlast;
            if (expected_writes.size() == 0) begin
                flag({"unexpected pixel write: ", show(got)});
                return;
            end
            want = expected_writes.pop_front();
            if (got.pixel_index !== want.pixel_index || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.cold_white !== want.cold_white || got.warm_white !== want.warm_white ||
                got.power_total !== want.power_total || got.last_write !== want.last_write)
                flag({"pixel write mismatch: expected ", show(want), " got ", show(got)});
        endfunction

        function void check_leftover();
            if (expected_writes.size() != 0)
                flag($sformatf("%0d pixel writes never arrived", expected_writes.size()));
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // channel_value[7:0], dim_level[15:8]
    logic        s_tuser   = 1'b0;  // frame_start
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;           // pixel_index, red, green, blue, cold, warm, power
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_count   = 0;

    pixel_write_tracker board = new();

    dmx_channels_to_pixel_colors DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on every input transaction
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_byte(s_tdata[7:0], s_tdata[15:8], s_tuser);
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_write(m_tdata, m_tlast);
    end

    // Present one byte and hold it until accepted; tvalid stays high into the next byte
    task automatic send_byte(input logic [7:0] value, input logic [7:0] dimmer,
                             input logic start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dimmer, value};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop tvalid, wait for every predicted write, then let the back end go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [PosW-1:0] group, input logic [CopiesW-1:0] copies);
        board.set_regs(group, copies);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GROUP;
        cfg_wdata <= CopiesW'(group);
        @(posedge aclk);
        cfg_index <= CFG_COPIES;
        cfg_wdata <= copies;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Register settings and frame-start rate (per mille) of each random phase
    task automatic pick_phase(input int phase, output logic [PosW-1:0] group,
                              output logic [CopiesW-1:0] copies, output int start_rate);
        case (phase)
            0: begin group = GROUP_RGB;   copies = 7'd1;  start_rate = 25; end
            1: begin
                group = GROUP_RGBW;
                copies = CopiesW'($urandom_range(1, 8));
                start_rate = 25;
            end
            2: begin group = GROUP_RGBCW; copies = COPIES_MAX; start_rate = 0; end
            3: begin
                group = PosW'($urandom_range(0, 7));
                copies = CopiesW'($urandom_range(0, 127));
                start_rate = 30;
            end
            4: begin group = GROUP_RGB; copies = COPIES_OVER; start_rate = 10; end
            5: begin
                group = GROUP_RGBW;
                copies = CopiesW'($urandom_range(0, 3));
                start_rate = 40;
            end
            6: begin
                group = PosW'($urandom_range(0, 7));
                copies = 7'd2;
                start_rate = 20;
            end
            default: begin
                group = GROUP_RGBCW;
                copies = CopiesW'($urandom_range(1, 16));
                start_rate = 15;
            end
        endcase
    endtask

    initial begin
        logic [PosW-1:0]    group;
        logic [CopiesW-1:0] copies;
        int                 start_rate;
        logic [7:0]         frame_dim;
        logic [7:0]         dimmer;
        logic               start;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 9;
        recv_idle_pct = 53;

        // Reset settings: RGB, one copy; full and zero dimmer
        send_byte(8'd255, 8'd255, 1'b1);
        send_byte(8'd0,   8'd255, 1'b0);
        send_byte(8'd255, 8'd255, 1'b0);
        send_byte(8'd128, 8'd0,   1'b0);
        send_byte(8'd1,   8'd0,   1'b0);
        send_byte(8'd255, 8'd0,   1'b0);
        settle();

        // RGBW, three copies
        write_regs(GROUP_RGBW, 7'd3);
        send_byte(8'd200, 8'd128, 1'b1);
        send_byte(8'd100, 8'd128, 1'b0);
        send_byte(8'd50,  8'd128, 1'b0);
        send_byte(8'd77,  8'd1,   1'b0);
        settle();

        // RGB plus two whites with zero copies: tuple consumed, nothing written;
        // then leave a tuple half filled
        write_regs(GROUP_RGBCW, 7'd0);
        send_byte(8'd10, 8'd200, 1'b1);
        send_byte(8'd20, 8'd200, 1'b0);
        send_byte(8'd30, 8'd200, 1'b0);
        send_byte(8'd40, 8'd200, 1'b0);
        send_byte(8'd50, 8'd200, 1'b0);
        send_byte(8'd255, 8'd255, 1'b0);
        send_byte(8'd255, 8'd255, 1'b0);
        settle();

        // Shrink the group mid-tuple to an unknown size, copies above the cap;
        // full white drives the total into saturation
        write_regs(GROUP_UNKNOWN, COPIES_OVER);
        send_byte(8'd255, 8'd255, 1'b0);
        send_byte(8'd255, 8'd255, 1'b0);
        send_byte(8'd255, 8'd255, 1'b0);
        send_byte(8'd255, 8'd255, 1'b0);
        settle();

        // Random frames under changing settings and idling
        frame_dim = 8'd255;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 53;
                recv_idle_pct = 9;
            end else if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_phase(phase, group, copies, start_rate);
            write_regs(group, copies);
            for (int i = 0; i < PHASE_BYTES; i++) begin
                if (i == 0) start = ($urandom_range(0, 99) < 80);
                else start = ($urandom_range(0, 999) < start_rate);
                if (start) frame_dim = 8'($urandom_range(0, 255));
                dimmer = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : frame_dim;
                send_byte(8'($urandom_range(0, 255)), dimmer, start);
            end
            settle();
        end

        board.check_leftover();
        if (board.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dmxpx_pkg.sv
hdl/dmxpx_front.sv
hdl/dmxpx_queue.sv
hdl/dmxpx_back.sv
hdl/dmx_channels_to_pixel_colors.sv
verif/tb_top.sv
